// ===== src/order_book_table_macros.svh =====
// ----------------------------------------------------------------------------
// order_book_table_macros
// assertion macros shared by the order book checker
// ----------------------------------------------------------------------------
`ifndef ORDER_BOOK_TABLE_MACROS_SVH
`define ORDER_BOOK_TABLE_MACROS_SVH

// same-cycle implication
`define OBT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("order book check failed");

// next-cycle implication
`define OBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("order book check failed");

`endif

// ===== src/obt_pkg.sv =====
// ----------------------------------------------------------------------------
// obt_pkg
// types, constants and helpers of the order book table
// ----------------------------------------------------------------------------
package obt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_MODIFY,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_DUP      = 3'd1,
        STS_ABSENT   = 3'd2,
        STS_MISMATCH = 3'd3,
        STS_FULL     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_RESP
    } t_bk_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] order_id;
        logic        side_sell;
        logic [31:0] quantity;
        logic [31:0] price_ticks;
    } t_cmd;

    typedef struct packed {
        logic [31:0] order_id;
        logic        side_sell;
        logic [31:0] quantity;
        logic [31:0] price_ticks;
    } t_entry;

    typedef struct packed {
        logic        accepted;
        t_status     status;
        logic [31:0] duplicate_count;
        logic [31:0] invalid_count;
    } t_rsp;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ===== src/obt_if.sv =====
// ----------------------------------------------------------------------------
// obt_if
// request and response channels of the order book table
// ----------------------------------------------------------------------------
interface obt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] order_id;
    logic        side_sell;
    logic [31:0] quantity;
    logic [31:0] price_ticks;

    modport source (
        output valid, req_type, order_id, side_sell, quantity, price_ticks,
        input  ready
    );
    modport sink (
        input  valid, req_type, order_id, side_sell, quantity, price_ticks,
        output ready
    );
endinterface

interface obt_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  status;
    logic [31:0] duplicate_count;
    logic [31:0] invalid_count;

    modport source (
        output valid, accepted, status, duplicate_count, invalid_count,
        input  ready
    );
    modport sink (
        input  valid, accepted, status, duplicate_count, invalid_count,
        output ready
    );
endinterface

// ===== src/obt_front.sv =====
// ----------------------------------------------------------------------------
// obt_front
// accepts request words, decodes the request type and queues commands
// ----------------------------------------------------------------------------
module obt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    obt_req_if.sink       i_req,
    output obt_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);

    obt_pkg::t_cmd                  r_q [obt_pkg::QUEUE_DEPTH];
    logic [obt_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [obt_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [obt_pkg::QCNT_W-1:0]     r_count, n_count;
    obt_pkg::t_cmd                  w_cmd;
    logic                           w_push;
    logic                           w_pop;

    // request type decode
    always_comb begin
        w_cmd.order_id    = i_req.order_id;
        w_cmd.side_sell   = i_req.side_sell;
        w_cmd.quantity    = i_req.quantity;
        w_cmd.price_ticks = i_req.price_ticks;
        unique case (i_req.req_type)
            obt_pkg::REQ_ADD:    w_cmd.op = obt_pkg::OP_ADD;
            obt_pkg::REQ_REMOVE: w_cmd.op = obt_pkg::OP_REMOVE;
            obt_pkg::REQ_MODIFY: w_cmd.op = obt_pkg::OP_MODIFY;
            default:             w_cmd.op = obt_pkg::OP_NOP;
        endcase
    end

    assign i_req.ready = (r_count != obt_pkg::QCNT_W'(obt_pkg::QUEUE_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == obt_pkg::QPTR_W'(obt_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == obt_pkg::QPTR_W'(obt_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== src/obt_back.sv =====
// ----------------------------------------------------------------------------
// obt_back
// scans the order table one slot a cycle, applies commands, holds counters
// ----------------------------------------------------------------------------
module obt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  obt_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    obt_rsp_if.source     o_rsp
);

    localparam logic [obt_pkg::IDX_W-1:0] LAST_IDX =
        obt_pkg::IDX_W'(obt_pkg::TABLE_ENTRIES - 1);

    obt_pkg::t_entry                   r_mem [obt_pkg::TABLE_ENTRIES];
    logic [obt_pkg::TABLE_ENTRIES-1:0] r_valid;

    obt_pkg::t_bk_state          r_state, n_state;
    obt_pkg::t_cmd               r_cmd, n_cmd;
    logic [obt_pkg::IDX_W-1:0]   r_addr, n_addr;
    logic                        r_issued_all, n_issued_all;
    logic                        r_pend, n_pend;
    obt_pkg::t_entry             r_rd;
    logic                        r_rd_vld;
    logic [obt_pkg::IDX_W-1:0]   r_rd_idx;
    logic                        r_free_found, n_free_found;
    logic [obt_pkg::IDX_W-1:0]   r_free_idx, n_free_idx;
    logic [31:0]                 r_dup, n_dup;
    logic [31:0]                 r_inv, n_inv;
    logic                        r_res_acc, n_res_acc;
    obt_pkg::t_status            r_res_sts, n_res_sts;
    obt_pkg::t_rsp               r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    logic                        w_issue;
    logic                        w_hit;
    logic                        w_free;
    logic                        w_last;
    logic                        w_we;
    logic [obt_pkg::IDX_W-1:0]   w_wr_idx;
    obt_pkg::t_entry             w_wr_data;
    logic                        w_set_valid;
    logic                        w_clr_valid;

    assign w_wr_data.order_id    = r_cmd.order_id;
    assign w_wr_data.side_sell   = r_cmd.side_sell;
    assign w_wr_data.quantity    = r_cmd.quantity;
    assign w_wr_data.price_ticks = r_cmd.price_ticks;

    assign w_hit  = r_pend && r_rd_vld && (r_rd.order_id == r_cmd.order_id);
    assign w_free = r_pend && !r_rd_vld;
    assign w_last = r_pend && (r_rd_idx == LAST_IDX);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_issued_all = r_issued_all;
        n_pend       = r_pend;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_dup        = r_dup;
        n_inv        = r_inv;
        n_res_acc    = r_res_acc;
        n_res_sts    = r_res_sts;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        o_cmd_pop    = 1'b0;
        w_issue      = 1'b0;
        w_we         = 1'b0;
        w_wr_idx     = r_rd_idx;
        w_set_valid  = 1'b0;
        w_clr_valid  = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            obt_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop    = 1'b1;
                    n_cmd        = i_cmd;
                    n_addr       = '0;
                    n_issued_all = 1'b0;
                    n_pend       = 1'b0;
                    n_free_found = 1'b0;
                    if (i_cmd.op == obt_pkg::OP_NOP) begin
                        n_res_acc = 1'b0;
                        n_res_sts = obt_pkg::STS_OK;
                        n_state   = obt_pkg::BK_RESP;
                    end else begin
                        n_state = obt_pkg::BK_SCAN;
                    end
                end
            end
            obt_pkg::BK_SCAN: begin
                w_issue = !r_issued_all;
                n_pend  = !r_issued_all;
                if (!r_issued_all) begin
                    if (r_addr == LAST_IDX) begin
                        n_issued_all = 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (w_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_rd_idx;
                end
                if (w_hit || w_last) begin
                    n_state = obt_pkg::BK_RESP;
                    n_res_acc = 1'b0;
                    case (r_cmd.op) inside
                        obt_pkg::OP_ADD: begin
                            if (w_hit) begin
                                n_dup     = obt_pkg::sat_inc(r_dup);
                                n_res_sts = obt_pkg::STS_DUP;
                            end else if (r_free_found || w_free) begin
                                w_we        = 1'b1;
                                w_set_valid = 1'b1;
                                w_wr_idx    = r_free_found ? r_free_idx : r_rd_idx;
                                n_res_acc   = 1'b1;
                                n_res_sts   = obt_pkg::STS_OK;
                            end else begin
                                n_res_sts = obt_pkg::STS_FULL;
                            end
                        end
                        obt_pkg::OP_REMOVE, obt_pkg::OP_MODIFY: begin
                            if (!w_hit) begin
                                n_inv     = obt_pkg::sat_inc(r_inv);
                                n_res_sts = obt_pkg::STS_ABSENT;
                            end else if ((r_rd.price_ticks != r_cmd.price_ticks) ||
                                         (r_rd.side_sell != r_cmd.side_sell)) begin
                                n_inv     = obt_pkg::sat_inc(r_inv);
                                n_res_sts = obt_pkg::STS_MISMATCH;
                            end else begin
                                n_res_acc = 1'b1;
                                n_res_sts = obt_pkg::STS_OK;
                                if (r_cmd.op == obt_pkg::OP_REMOVE) begin
                                    w_clr_valid = 1'b1;
                                end else begin
                                    w_we = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_res_sts = obt_pkg::STS_OK;
                        end
                    endcase
                end
            end
            obt_pkg::BK_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out.accepted        = r_res_acc;
                    n_out.status          = r_res_sts;
                    n_out.duplicate_count = r_dup;
                    n_out.invalid_count   = r_inv;
                    n_out_valid           = 1'b1;
                    n_state               = obt_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = obt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= obt_pkg::BK_IDLE;
            r_issued_all <= 1'b0;
            r_pend       <= 1'b0;
            r_free_found <= 1'b0;
            r_dup        <= '0;
            r_inv        <= '0;
            r_out_valid  <= 1'b0;
            r_valid      <= '0;
        end else begin
            r_state      <= n_state;
            r_issued_all <= n_issued_all;
            r_pend       <= n_pend;
            r_free_found <= n_free_found;
            r_dup        <= n_dup;
            r_inv        <= n_inv;
            r_out_valid  <= n_out_valid;
            if (w_set_valid) begin
                r_valid[w_wr_idx] <= 1'b1;
            end
            if (w_clr_valid) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_free_idx <= n_free_idx;
        r_res_acc  <= n_res_acc;
        r_res_sts  <= n_res_sts;
        r_out      <= n_out;
        if (w_issue) begin
            r_rd_vld <= r_valid[r_addr];
            r_rd_idx <= r_addr;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_idx] <= w_wr_data;
        end
        if (w_issue) begin
            r_rd <= r_mem[r_addr];
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.accepted        = r_out.accepted;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.duplicate_count = r_out.duplicate_count;
    assign o_rsp.invalid_count   = r_out.invalid_count;

endmodule

// ===== src/order_book_table.sv =====
// ----------------------------------------------------------------------------
// order_book_table
// Table of live orders with add, remove and modify requests. Requests are
// taken into a two-deep command queue while the table engine works, so the
// request side keeps moving until that queue is full, also while a response
// waits. Each request returns exactly one response word. For an add,
// remove or modify the engine takes the command, walks over the table one
// slot per cycle through the single registered read port of the table
// memory, and then loads the response register. The walk stops at the
// first slot holding the id, so an add that is not a duplicate or a
// request for an absent id costs the full walk. An unknown request type
// skips the walk and goes straight to the response. A response not yet
// taken holds the engine in its response state until it is. Both counters
// saturate.
// ----------------------------------------------------------------------------
module order_book_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    obt_req_if.sink   i_req,
    obt_rsp_if.source o_rsp
);

    obt_pkg::t_cmd w_cmd;
    logic          w_cmd_valid;
    logic          w_cmd_pop;

    obt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    obt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== src/obt_checker.sv =====
// ----------------------------------------------------------------------------
// obt_checker
// port-level checks on the order book response channel
// ----------------------------------------------------------------------------
`include "order_book_table_macros.svh"

module obt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_accepted,
    input logic [2:0]  i_status,
    input logic [31:0] i_dup_count,
    input logic [31:0] i_inv_count
);

    logic [67:0] w_rsp_word;
    logic        w_dup_sts;
    logic        w_inv_sts;

    assign w_rsp_word = {i_accepted, i_status, i_dup_count, i_inv_count};
    assign w_dup_sts  = (i_status == obt_pkg::STS_DUP);
    assign w_inv_sts  = (i_status == obt_pkg::STS_ABSENT) ||
                        (i_status == obt_pkg::STS_MISMATCH);

    // stalled response word holds
`OBT_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(w_rsp_word))

    // a table change always reports ok
`OBT_ASSERT_SAME(a_acc_ok, i_rsp_valid && i_accepted, i_status == obt_pkg::STS_OK)

    // a duplicate was counted
`OBT_ASSERT_SAME(a_dup_cnt, i_rsp_valid && w_dup_sts, i_dup_count != 32'd0)

    // a failed match was counted
`OBT_ASSERT_SAME(a_inv_cnt, i_rsp_valid && w_inv_sts, i_inv_count != 32'd0)

endmodule

bind order_book_table obt_checker u_obt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_accepted  (o_rsp.accepted),
    .i_status    (o_rsp.status),
    .i_dup_count (o_rsp.duplicate_count),
    .i_inv_count (o_rsp.invalid_count)
);

// ===== test/tb_order_book_table.sv =====
// ----------------------------------------------------------------------------
// tb_order_book_table
// Self-checking bench for the order book table. A queue of add, remove,
// modify and unknown requests feeds a clocked driver; a clocked monitor takes
// each response word and compares it field by field against a book kept in
// the bench. Starts with short directed cases, then runs four random phases
// that differ in sender gaps, receiver stalls and share of adds.
// ----------------------------------------------------------------------------
module tb_order_book_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE   = 96;
    localparam int PHASE_ITEMS = 350;
    localparam int DRAIN_WAIT  = 90;
    localparam int CYCLE_LIMIT = 800_000;

    typedef struct packed {
        logic        side_sell;
        logic [31:0] price_ticks;
    } t_live_order;

    logic i_clk = 1'b0;
    logic i_rst_n;

    obt_req_if req_ch ();
    obt_rsp_if rsp_ch ();

    order_book_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // book state as seen by accepted requests
    logic        book_valid [obt_pkg::TABLE_ENTRIES];
    logic [31:0] book_id    [obt_pkg::TABLE_ENTRIES];
    logic        book_side  [obt_pkg::TABLE_ENTRIES];
    logic [31:0] book_qty   [obt_pkg::TABLE_ENTRIES];
    logic [31:0] book_price [obt_pkg::TABLE_ENTRIES];
    logic [31:0] dup_total;
    logic [31:0] invalid_total;

    // live orders as planned at generation time, used to aim removes and modifies
    t_live_order planned_book [logic [31:0]];
    logic [31:0] id_pool [POOL_SIZE];

    obt_pkg::t_cmd pending_q [$];
    obt_pkg::t_rsp expected_rsp_q [$];
    obt_pkg::t_cmd req_word;
    obt_pkg::t_rsp got_rsp;
    obt_pkg::t_rsp exp_rsp;

    int n_queued   = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int cycle_cnt  = 0;

    function automatic obt_pkg::t_rsp book_apply(input obt_pkg::t_cmd c);
        obt_pkg::t_rsp r;
        int            hit;
        int            free_slot;
        int            i;
        r.accepted = 1'b0;
        r.status = obt_pkg::STS_OK;
        hit = -1;
        free_slot = -1;
        for (i = 0; i < obt_pkg::TABLE_ENTRIES; i++) begin
            if (hit < 0 && book_valid[i] && book_id[i] == c.order_id) begin
                hit = i;
            end
            if (free_slot < 0 && !book_valid[i]) begin
                free_slot = i;
            end
        end
        case (c.op) inside
            obt_pkg::OP_ADD: begin
                if (hit >= 0) begin
                    if (dup_total != 32'hFFFF_FFFF) begin
                        dup_total = dup_total + 32'd1;
                    end
                    r.status = obt_pkg::STS_DUP;
                end else if (free_slot < 0) begin
                    r.status = obt_pkg::STS_FULL;
                end else begin
                    book_valid[free_slot] = 1'b1;
                    book_id[free_slot] = c.order_id;
                    book_side[free_slot] = c.side_sell;
                    book_qty[free_slot] = c.quantity;
                    book_price[free_slot] = c.price_ticks;
                    r.accepted = 1'b1;
                end
            end
            obt_pkg::OP_REMOVE, obt_pkg::OP_MODIFY: begin
                if (hit < 0 || book_price[hit] != c.price_ticks
                        || book_side[hit] != c.side_sell) begin
                    if (invalid_total != 32'hFFFF_FFFF) begin
                        invalid_total = invalid_total + 32'd1;
                    end
                    r.status = (hit < 0) ? obt_pkg::STS_ABSENT : obt_pkg::STS_MISMATCH;
                end else begin
                    if (c.op == obt_pkg::OP_REMOVE) begin
                        book_valid[hit] = 1'b0;
                    end else begin
                        book_qty[hit] = c.quantity;
                    end
                    r.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.duplicate_count = dup_total;
        r.invalid_count = invalid_total;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(input obt_pkg::t_op op, input logic [31:0] id,
                                 input logic side, input logic [31:0] qty,
                                 input logic [31:0] price);
        obt_pkg::t_cmd c;
        t_live_order   o;
        c.op = op;
        c.order_id = id;
        c.side_sell = side;
        c.quantity = qty;
        c.price_ticks = price;
        o.side_sell = side;
        o.price_ticks = price;
        pending_q.push_back(c);
        n_queued++;
        case (op)
            obt_pkg::OP_ADD: begin
                if (!planned_book.exists(id) &&
                        planned_book.num() < obt_pkg::TABLE_ENTRIES) begin
                    planned_book[id] = o;
                end
            end
            obt_pkg::OP_REMOVE: begin
                if (planned_book.exists(id) && planned_book[id] == o) begin
                    planned_book.delete(id);
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_random_request(input int add_pct);
        int            roll;
        int            k;
        obt_pkg::t_op  op;
        logic [31:0]   id;
        logic          side;
        logic [31:0]   price;
        roll = $urandom_range(99);
        if (roll < 2) begin
            queue_request(obt_pkg::t_op'($urandom_range(3)), $urandom,
                          1'($urandom_range(1)), rand_word(), rand_word());
        end else if (roll < 2 + add_pct) begin
            queue_request(obt_pkg::OP_ADD, id_pool[$urandom_range(POOL_SIZE - 1)],
                          1'($urandom_range(1)), rand_word(), rand_word());
        end else begin
            op = $urandom_range(1) ? obt_pkg::OP_MODIFY : obt_pkg::OP_REMOVE;
            id = id_pool[$urandom_range(POOL_SIZE - 1)];
            for (k = 0; k < 8; k++) begin
                if (!planned_book.exists(id)) begin
                    id = id_pool[$urandom_range(POOL_SIZE - 1)];
                end
            end
            if (planned_book.exists(id)) begin
                side = planned_book[id].side_sell;
                price = planned_book[id].price_ticks;
                if ($urandom_range(99) < 25) begin
                    if ($urandom_range(1)) begin
                        side = ~side;
                    end else begin
                        price = price ^ (32'h1 << $urandom_range(31));
                    end
                end
            end else begin
                side = 1'($urandom_range(1));
                price = rand_word();
            end
            queue_request(op, id, side, rand_word(), price);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t mismatch %s expected %h actual %h", $realtime, field, want, seen);
            n_errors++;
        end
    endtask

    task automatic wait_drained();
        while (!(n_accepted == n_queued && expected_rsp_q.size() == 0)) begin
            @(posedge i_clk);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_rsp_q.push_back(book_apply(req_word));
                n_accepted++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    req_word = pending_q.pop_front();
                    req_ch.req_type <= req_word.op;
                    req_ch.order_id <= req_word.order_id;
                    req_ch.side_sell <= req_word.side_sell;
                    req_ch.quantity <= req_word.quantity;
                    req_ch.price_ticks <= req_word.price_ticks;
                    req_ch.valid <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got_rsp.accepted = rsp_ch.accepted;
                got_rsp.status = obt_pkg::t_status'(rsp_ch.status);
                got_rsp.duplicate_count = rsp_ch.duplicate_count;
                got_rsp.invalid_count = rsp_ch.invalid_count;
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t unexpected word expected none actual %h",
                             $realtime, got_rsp);
                    n_errors++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    check_field("accepted", 32'(exp_rsp.accepted), 32'(got_rsp.accepted));
                    check_field("status", 32'(exp_rsp.status), 32'(got_rsp.status));
                    check_field("duplicate_count", exp_rsp.duplicate_count,
                                got_rsp.duplicate_count);
                    check_field("invalid_count", exp_rsp.invalid_count,
                                got_rsp.invalid_count);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int n;
        int ph;
        int add_pct [4];
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = obt_pkg::REQ_ADD;
        req_ch.order_id = '0;
        req_ch.side_sell = 1'b0;
        req_ch.quantity = '0;
        req_ch.price_ticks = '0;
        rsp_ch.ready = 1'b0;
        for (n = 0; n < obt_pkg::TABLE_ENTRIES; n++) begin
            book_valid[n] = 1'b0;
            book_id[n] = '0;
            book_side[n] = 1'b0;
            book_qty[n] = '0;
            book_price[n] = '0;
        end
        dup_total = '0;
        invalid_total = '0;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < POOL_SIZE; n++) begin
            id_pool[n] = $urandom;
        end
        add_pct[0] = 70;
        add_pct[1] = 45;
        add_pct[2] = 60;
        add_pct[3] = 35;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases on an empty book, field extremes, every request kind
        queue_request(obt_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, 32'h0);
        queue_request(obt_pkg::OP_MODIFY, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
        queue_request(obt_pkg::OP_ADD, 32'h0, 1'b0, 32'h0, 32'h0);
        queue_request(obt_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(obt_pkg::OP_ADD, 32'h0, 1'b1, 32'h1234_5678, 32'h0);
        queue_request(obt_pkg::OP_REMOVE, 32'h0, 1'b1, 32'h0, 32'h0);
        queue_request(obt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'hFFFF_FFFE);
        queue_request(obt_pkg::OP_MODIFY, 32'hFFFF_FFFF, 1'b1, 32'h5, 32'hFFFF_FFFF);
        queue_request(obt_pkg::OP_MODIFY, 32'h0, 1'b0, 32'hFFFF_FFFF, 32'h0);
        queue_request(obt_pkg::OP_NOP, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(obt_pkg::OP_REMOVE, 32'h0, 1'b0, 32'hFFFF_FFFF, 32'h0);
        queue_request(obt_pkg::OP_REMOVE, 32'h0, 1'b0, 32'h0, 32'h0);
        queue_request(obt_pkg::OP_ADD, 32'h0, 1'b0, 32'hAAAA_AAAA, 32'h8000_0000);
        queue_request(obt_pkg::OP_ADD, 32'h5555_5555, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_request(obt_pkg::OP_MODIFY, 32'h0, 1'b0, 32'h0, 32'h7FFF_FFFF);
        queue_request(obt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'hFFFF_FFFF);
        queue_request(obt_pkg::OP_NOP, 32'h0, 1'b0, 32'h0, 32'h0);
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                queue_random_request(add_pct[ph]);
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_rsp_q.size() != 0) begin
            $display("%0t words missing expected %0d actual 0", $realtime,
                     expected_rsp_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
